[rtl/otet_pkg.sv]
`timescale 1ns / 1ps

package otet_pkg;

    localparam int ID_W      = 16;
    localparam int TRIG_W    = 32;
    localparam int HANDLER_W = 8;
    localparam int PARAM_W   = 16;
    localparam int KIND_W    = 2;
    localparam int MAX_FIRE  = 16;
    localparam int FIRE_W    = $clog2(MAX_FIRE + 1);

    typedef enum logic [2:0] {
        OP_ADD         = 3'd0,
        OP_REM_PARAM   = 3'd1,
        OP_REM_HANDLER = 3'd2,
        OP_REM_BOTH    = 3'd3,
        OP_REM_ID      = 3'd4,
        OP_TICK        = 3'd5,
        OP_CLEAR       = 3'd6
    } opcode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DONE   = 2'd0,
        KIND_FIRED  = 2'd1,
        KIND_FULL   = 2'd2,
        KIND_NONE   = 2'd3
    } result_kind_t;

    typedef enum logic [2:0] {
        CMD_HOLD    = 3'd0,
        CMD_CLEAR   = 3'd1,
        CMD_MARK    = 3'd2,
        CMD_SHIFT   = 3'd3,
        CMD_COMPACT = 3'd4
    } cell_cmd_t;

    typedef struct packed {
        logic [TRIG_W-1:0]    trigger;
        logic [ID_W-1:0]      id;
        logic [HANDLER_W-1:0] handler;
        logic [PARAM_W-1:0]   param;
    } entry_t;

    typedef struct packed {
        cell_cmd_t            cmd;
        opcode_t              op;
        logic [ID_W-1:0]      id;
        logic [HANDLER_W-1:0] handler;
        logic [PARAM_W-1:0]   param;
    } cell_ctl_t;

endpackage

[rtl/otet_cell.sv]
`timescale 1ns / 1ps

module otet_cell
    import otet_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl,
    input  logic      upper_valid,
    input  entry_t    upper_data,
    input  logic      lower_valid,
    output logic      valid,
    output entry_t    data,
    output logic      hit
);

    logic   valid_reg;
    entry_t data_reg;
    logic   match;

    always_comb begin
        case (ctl.op)
            OP_REM_PARAM:   match = (data_reg.param == ctl.param);
            OP_REM_HANDLER: match = (data_reg.handler == ctl.handler);
            OP_REM_BOTH:    match = (data_reg.handler == ctl.handler) &&
                                    (data_reg.param == ctl.param);
            default:        match = (data_reg.id == ctl.id);
        endcase
    end

    assign hit   = (ctl.cmd == CMD_MARK) && valid_reg && match;
    assign valid = valid_reg;
    assign data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            unique case (ctl.cmd)
                CMD_HOLD: ;
                CMD_CLEAR: valid_reg <= 1'b0;
                CMD_MARK: begin
                    if (match) begin
                        valid_reg <= 1'b0;
                    end
                end
                CMD_SHIFT: valid_reg <= upper_valid;
                CMD_COMPACT: begin
                    if (!valid_reg) begin
                        valid_reg <= upper_valid;
                    end else if (!lower_valid) begin
                        valid_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (ctl.cmd)
            CMD_SHIFT: data_reg <= upper_data;
            CMD_COMPACT: begin
                if (!valid_reg) begin
                    data_reg <= upper_data;
                end
            end
            default: ;
        endcase
    end

endmodule

[rtl/ordered_timer_event_table.sv]
`timescale 1ns / 1ps
// Ordered timer event table.
// Input channel s_*: one request per operation (add, remove by param / handler /
// both / id, tick, clear). Result channel m_*: one result per request, or for a
// tick one result per expired entry in table order (at most 16), or a single
// "nothing expired" result; m_last marks the final result of a request.
// Entries live in a row of TABLE_DEPTH cells; each cell talks only to its
// neighbors. Add, remove and clear act on all cells in the accept cycle, then
// compaction closes the gaps. A tick rotates the row through the head cell,
// checking one entry per cycle unless the output stalls the rotation, then
// compacts.
// One request is in flight at a time; s_ready is high only when idle.
// The result register lets a new request be taken while a result waits.
// A stalled receiver holds the rotation only when an expired entry finds both
// the pending and output registers full.
// Synchronous reset empties the table and drops any pending result.
module ordered_timer_event_table
    import otet_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_opcode,
    input  logic [ID_W-1:0]      s_timer_id,
    input  logic [TRIG_W-1:0]    s_trigger_time,
    input  logic                 s_relative,
    input  logic [HANDLER_W-1:0] s_handler_tag,
    input  logic [PARAM_W-1:0]   s_param_tag,
    input  logic [TRIG_W-1:0]    s_current_round,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [KIND_W-1:0]    m_result_kind,
    output logic                 m_removed_any,
    output logic [ID_W-1:0]      m_fired_id,
    output logic [HANDLER_W-1:0] m_fired_handler,
    output logic [PARAM_W-1:0]   m_fired_param,
    output logic                 m_last
);

    localparam int CNT_W = $clog2(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROTATE,
        S_COMPACT,
        S_FINISH
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [FIRE_W-1:0]    fire_cnt_reg;
    logic [TRIG_W-1:0]    now_reg;
    logic                 is_tick_reg;
    result_kind_t         kind_reg;
    logic                 removed_reg;
    logic                 pend_valid_reg;
    entry_t               pend_reg;

    logic                 m_valid_reg;
    result_kind_t         m_kind_reg;
    logic                 m_removed_reg;
    entry_t               m_entry_reg;
    logic                 m_last_reg;

    logic                 accept;
    logic                 out_free;
    opcode_t              op;
    logic                 due;
    logic                 rot_stall;
    logic                 cnt_end;
    logic                 m_load;
    cell_ctl_t            ctl;
    logic                 feed_valid;
    entry_t               feed_data;
    entry_t               new_entry;

    logic [TABLE_DEPTH-1:0] cell_valid;
    entry_t                 cell_data [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_hit;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign op       = opcode_t'(s_opcode);
    assign cnt_end  = (cnt_reg == CNT_W'(TABLE_DEPTH - 1));

    assign due = cell_valid[0] && (cell_data[0].trigger <= now_reg) &&
                 (fire_cnt_reg < FIRE_W'(MAX_FIRE));
    assign rot_stall = due && pend_valid_reg && !out_free;

    assign m_load = ((state_reg == S_ROTATE) && !rot_stall && due && pend_valid_reg) ||
                    ((state_reg == S_FINISH) && out_free);

    always_comb begin
        new_entry.trigger = s_relative ? s_trigger_time + s_current_round
                                       : s_trigger_time;
        new_entry.id      = s_timer_id;
        new_entry.handler = s_handler_tag;
        new_entry.param   = s_param_tag;
    end

    always_comb begin
        ctl.op      = op;
        ctl.id      = s_timer_id;
        ctl.handler = s_handler_tag;
        ctl.param   = s_param_tag;
        ctl.cmd     = CMD_HOLD;
        feed_valid  = 1'b0;
        feed_data   = '0;
        unique case (state_reg)
            S_IDLE: begin
                feed_valid = 1'b1;
                feed_data  = new_entry;
                if (accept) begin
                    case (op) inside
                        OP_ADD:                                 ctl.cmd = CMD_COMPACT;
                        OP_REM_PARAM, OP_REM_HANDLER,
                        OP_REM_BOTH, OP_REM_ID:                 ctl.cmd = CMD_MARK;
                        OP_CLEAR:                               ctl.cmd = CMD_CLEAR;
                        default:                                ctl.cmd = CMD_HOLD;
                    endcase
                end
            end
            S_ROTATE: begin
                feed_valid = cell_valid[0] && !due;
                feed_data  = cell_data[0];
                ctl.cmd    = rot_stall ? CMD_HOLD : CMD_SHIFT;
            end
            S_COMPACT: ctl.cmd = CMD_COMPACT;
            S_FINISH:  ctl.cmd = CMD_HOLD;
            default:   ctl.cmd = CMD_HOLD;
        endcase
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic   up_valid;
        entry_t up_data;
        logic   lo_valid;

        if (i == TABLE_DEPTH - 1) begin : g_tail
            assign up_valid = feed_valid;
            assign up_data  = feed_data;
        end else begin : g_mid
            assign up_valid = cell_valid[i+1];
            assign up_data  = cell_data[i+1];
        end

        if (i == 0) begin : g_head
            assign lo_valid = 1'b1;
        end else begin : g_low
            assign lo_valid = cell_valid[i-1];
        end

        otet_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .upper_valid (up_valid),
            .upper_data  (up_data),
            .lower_valid (lo_valid),
            .valid       (cell_valid[i]),
            .data        (cell_data[i]),
            .hit         (cell_hit[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            fire_cnt_reg   <= '0;
        end else begin
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        now_reg        <= s_current_round;
                        cnt_reg        <= '0;
                        fire_cnt_reg   <= '0;
                        pend_valid_reg <= 1'b0;
                        is_tick_reg    <= (op == OP_TICK);
                        removed_reg    <= |cell_hit;
                        kind_reg       <= (op == OP_ADD && cell_valid[TABLE_DEPTH-1])
                                          ? KIND_FULL : KIND_DONE;
                        state_reg      <= (op == OP_TICK) ? S_ROTATE : S_COMPACT;
                    end
                end
                S_ROTATE: begin
                    if (!rot_stall) begin
                        if (due) begin
                            fire_cnt_reg   <= fire_cnt_reg + 1'b1;
                            pend_reg       <= cell_data[0];
                            pend_valid_reg <= 1'b1;
                            if (pend_valid_reg) begin
                                m_kind_reg    <= KIND_FIRED;
                                m_removed_reg <= 1'b0;
                                m_entry_reg   <= pend_reg;
                                m_last_reg    <= 1'b0;
                            end
                        end
                        if (cnt_end) begin
                            cnt_reg   <= '0;
                            state_reg <= S_COMPACT;
                        end else begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                S_COMPACT: begin
                    if (cnt_end) begin
                        cnt_reg   <= '0;
                        state_reg <= S_FINISH;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_last_reg <= 1'b1;
                        if (is_tick_reg) begin
                            m_removed_reg <= 1'b0;
                            if (pend_valid_reg) begin
                                m_kind_reg  <= KIND_FIRED;
                                m_entry_reg <= pend_reg;
                            end else begin
                                m_kind_reg  <= KIND_NONE;
                                m_entry_reg <= '0;
                            end
                        end else begin
                            m_kind_reg    <= kind_reg;
                            m_removed_reg <= removed_reg;
                            m_entry_reg   <= '0;
                        end
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_kind   = m_kind_reg;
    assign m_removed_any   = m_removed_reg;
    assign m_fired_id      = m_entry_reg.id;
    assign m_fired_handler = m_entry_reg.handler;
    assign m_fired_param   = m_entry_reg.param;
    assign m_last          = m_last_reg;

endmodule

[tb/tb_ordered_timer_event_table.sv]
`timescale 1ns / 1ps

module tb_ordered_timer_event_table;
    import otet_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 20;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef struct {
        logic [2:0]           op;
        logic [ID_W-1:0]      id;
        logic [TRIG_W-1:0]    trig;
        logic                 rel;
        logic [HANDLER_W-1:0] hnd;
        logic [PARAM_W-1:0]   par;
        logic [TRIG_W-1:0]    now;
    } request_t;

    typedef struct {
        result_kind_t         kind;
        logic                 removed;
        logic [ID_W-1:0]      id;
        logic [HANDLER_W-1:0] hnd;
        logic [PARAM_W-1:0]   par;
        logic                 last;
    } timer_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [2:0]           s_opcode = OP_ADD;
    logic [ID_W-1:0]      s_timer_id = '0;
    logic [TRIG_W-1:0]    s_trigger_time = '0;
    logic                 s_relative = 1'b0;
    logic [HANDLER_W-1:0] s_handler_tag = '0;
    logic [PARAM_W-1:0]   s_param_tag = '0;
    logic [TRIG_W-1:0]    s_current_round = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [KIND_W-1:0]    m_result_kind;
    logic                 m_removed_any;
    logic [ID_W-1:0]      m_fired_id;
    logic [HANDLER_W-1:0] m_fired_handler;
    logic [PARAM_W-1:0]   m_fired_param;
    logic                 m_last;

    request_t      request_backlog[$];
    timer_result_t awaited_results[$];
    entry_t        timer_list[$];
    request_t      next_req;
    timer_result_t want;
    logic [TRIG_W-1:0] round_now;
    bit  req_taken = 1'b0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  requests_made = 0;
    int  requests_done = 0;
    int  mismatches = 0;
    int  cycle_count = 0;

    ordered_timer_event_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_timer_id      (s_timer_id),
        .s_trigger_time  (s_trigger_time),
        .s_relative      (s_relative),
        .s_handler_tag   (s_handler_tag),
        .s_param_tag     (s_param_tag),
        .s_current_round (s_current_round),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_removed_any   (m_removed_any),
        .m_fired_id      (m_fired_id),
        .m_fired_handler (m_fired_handler),
        .m_fired_param   (m_fired_param),
        .m_last          (m_last)
    );

    always #5 aclk = ~aclk;

    // Table kept as a queue in insertion order; the block keeps it packed the same way.
    function automatic void apply_request(request_t r);
        entry_t        kept[$];
        entry_t        e;
        timer_result_t outs[$];
        logic [TRIG_W-1:0] due_round;
        logic hit;
        logic any_hit;
        int fired;
        fired = 0;
        any_hit = 1'b0;
        case (r.op)
            OP_ADD: begin
                if (timer_list.size() >= TABLE_DEPTH) begin
                    outs.push_back('{KIND_FULL, 1'b0, '0, '0, '0, 1'b0});
                end else begin
                    due_round = r.rel ? r.trig + r.now : r.trig;
                    e.trigger = due_round;
                    e.id = r.id;
                    e.handler = r.hnd;
                    e.param = r.par;
                    timer_list.push_back(e);
                    outs.push_back('{KIND_DONE, 1'b0, '0, '0, '0, 1'b0});
                end
            end
            OP_REM_PARAM, OP_REM_HANDLER, OP_REM_BOTH, OP_REM_ID: begin
                foreach (timer_list[i]) begin
                    e = timer_list[i];
                    case (r.op)
                        OP_REM_PARAM:   hit = e.param == r.par;
                        OP_REM_HANDLER: hit = e.handler == r.hnd;
                        OP_REM_BOTH:    hit = e.handler == r.hnd && e.param == r.par;
                        default:        hit = e.id == r.id;
                    endcase
                    if (hit) begin
                        any_hit = 1'b1;
                    end else begin
                        kept.push_back(e);
                    end
                end
                timer_list = kept;
                outs.push_back('{KIND_DONE, any_hit, '0, '0, '0, 1'b0});
            end
            OP_TICK: begin
                foreach (timer_list[i]) begin
                    e = timer_list[i];
                    if (e.trigger <= r.now && fired < MAX_FIRE) begin
                        outs.push_back('{KIND_FIRED, 1'b0, e.id, e.handler, e.param, 1'b0});
                        fired++;
                    end else begin
                        kept.push_back(e);
                    end
                end
                timer_list = kept;
                if (fired == 0) begin
                    outs.push_back('{KIND_NONE, 1'b0, '0, '0, '0, 1'b0});
                end
            end
            default: begin
                if (r.op == OP_CLEAR) begin
                    timer_list.delete();
                end
                outs.push_back('{KIND_DONE, 1'b0, '0, '0, '0, 1'b0});
            end
        endcase
        outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i]) begin
            awaited_results.push_back(outs[i]);
        end
    endfunction

    task automatic compare_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
            mismatches++;
        end
    endtask

    task automatic queue_request(logic [2:0] op, logic [ID_W-1:0] id, logic [TRIG_W-1:0] trig,
                                 logic rel, logic [HANDLER_W-1:0] hnd, logic [PARAM_W-1:0] par,
                                 logic [TRIG_W-1:0] now);
        request_backlog.push_back('{op, id, trig, rel, hnd, par, now});
        requests_made++;
    endtask

    // Small pools so removals hit; now and then a full-width value.
    function automatic logic [ID_W-1:0] pick_id();
        return ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [HANDLER_W-1:0] pick_handler();
        return ($urandom_range(0, 9) == 0) ? HANDLER_W'($urandom) :
            HANDLER_W'($urandom_range(0, 3));
    endfunction

    function automatic logic [PARAM_W-1:0] pick_param();
        return ($urandom_range(0, 9) == 0) ? PARAM_W'($urandom) : PARAM_W'($urandom_range(0, 3));
    endfunction

    task automatic queue_random_scene();
        int pick;
        int burst;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            if ($urandom_range(0, 1)) begin
                queue_request(OP_ADD, pick_id(), $urandom_range(0, 12), 1'b1, pick_handler(),
                              pick_param(), round_now);
            end else begin
                queue_request(OP_ADD, pick_id(), round_now + $urandom_range(0, 12), 1'b0,
                              pick_handler(), pick_param(), $urandom);
            end
        end else if (pick < 60) begin
            queue_request(3'($urandom_range(OP_REM_PARAM, OP_REM_ID)), pick_id(), $urandom,
                          1'($urandom), pick_handler(), pick_param(), $urandom);
        end else if (pick < 85) begin
            round_now += $urandom_range(0, 6);
            queue_request(OP_TICK, ID_W'($urandom), $urandom, 1'($urandom),
                          HANDLER_W'($urandom), PARAM_W'($urandom), round_now);
        end else if (pick < 90) begin
            // fill (often past full), then let the burst's timers expire at once
            burst = $urandom_range(8, 18);
            repeat (burst) begin
                queue_request(OP_ADD, pick_id(), $urandom_range(0, 12), 1'b1, pick_handler(),
                              pick_param(), round_now);
            end
            round_now += 20;
            queue_request(OP_TICK, ID_W'($urandom), $urandom, 1'($urandom),
                          HANDLER_W'($urandom), PARAM_W'($urandom), round_now);
        end else if (pick < 93) begin
            queue_request(OP_CLEAR, ID_W'($urandom), $urandom, 1'($urandom),
                          HANDLER_W'($urandom), PARAM_W'($urandom), $urandom);
        end else if (pick < 95) begin
            queue_request(OP_UNUSED, ID_W'($urandom), $urandom, 1'($urandom),
                          HANDLER_W'($urandom), PARAM_W'($urandom), $urandom);
        end else if (pick < 98) begin
            queue_request(OP_ADD, ID_W'($urandom), $urandom, 1'($urandom),
                          HANDLER_W'($urandom), PARAM_W'($urandom), $urandom);
        end else begin
            queue_request(OP_TICK, ID_W'($urandom), $urandom, 1'($urandom),
                          HANDLER_W'($urandom), PARAM_W'($urandom), $urandom);
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (requests_done != requests_made || awaited_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || req_taken)) begin
            if (request_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_req = request_backlog.pop_front();
                s_valid         <= 1'b1;
                s_opcode        <= next_req.op;
                s_timer_id      <= next_req.id;
                s_trigger_time  <= next_req.trig;
                s_relative      <= next_req.rel;
                s_handler_tag   <= next_req.hnd;
                s_param_tag     <= next_req.par;
                s_current_round <= next_req.now;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        req_taken = aresetn && s_valid && s_ready;
        if (req_taken) begin
            apply_request('{s_opcode, s_timer_id, s_trigger_time, s_relative, s_handler_tag,
                            s_param_tag, s_current_round});
            requests_done++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result with none awaited: result_kind 0x%0h", m_result_kind);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                compare_field("result_kind", 32'(want.kind), 32'(m_result_kind));
                compare_field("removed_any", 32'(want.removed), 32'(m_removed_any));
                compare_field("fired_id", 32'(want.id), 32'(m_fired_id));
                compare_field("fired_handler", 32'(want.hnd), 32'(m_fired_handler));
                compare_field("fired_param", 32'(want.par), 32'(m_fired_param));
                compare_field("last", 32'(want.last), 32'(m_last));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** ordered_timer_event_table: FAILED **");
            $finish;
        end
    end

    initial begin
        int phase_target;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // extremes, wrapped relative triggers, fill to full
        queue_request(OP_ADD, 16'h0000, 32'h0, 1'b0, 8'h00, 16'h0000, 32'h0);
        queue_request(OP_ADD, 16'hffff, 32'hffff_ffff, 1'b0, 8'hff, 16'hffff, 32'hffff_ffff);
        queue_request(OP_ADD, 16'h0002, 32'd10, 1'b1, 8'h01, 16'h0001, 32'hffff_fff8);
        queue_request(OP_ADD, 16'h0003, 32'hffff_ffff, 1'b1, 8'h02, 16'h0002, 32'h1);
        for (int i = 4; i < TABLE_DEPTH; i++) begin
            queue_request(OP_ADD, ID_W'(i), TRIG_W'(i), 1'b0, HANDLER_W'(i % 4),
                          PARAM_W'(i % 3), 32'h0);
        end
        queue_request(OP_ADD, 16'h00aa, 32'h5, 1'b0, 8'h55, 16'haaaa, 32'h0);
        queue_request(OP_TICK, 16'h0, 32'h0, 1'b0, 8'h0, 16'h0, 32'h1);
        queue_request(OP_TICK, 16'h0, 32'h0, 1'b0, 8'h0, 16'h0, 32'h0);
        queue_request(OP_REM_PARAM, 16'h0, 32'h0, 1'b0, 8'h0, 16'h1234, 32'h0);
        queue_request(OP_REM_PARAM, 16'h0, 32'h0, 1'b0, 8'h0, 16'hffff, 32'h0);
        queue_request(OP_REM_HANDLER, 16'h0, 32'h0, 1'b0, 8'h01, 16'h0, 32'h0);
        queue_request(OP_REM_BOTH, 16'h0, 32'h0, 1'b0, 8'h02, 16'h0002, 32'h0);
        queue_request(OP_REM_ID, 16'h0005, 32'h0, 1'b0, 8'h0, 16'h0, 32'h0);
        queue_request(OP_UNUSED, 16'hffff, 32'hffff_ffff, 1'b1, 8'hff, 16'hffff, 32'hffff_ffff);
        queue_request(OP_TICK, 16'h0, 32'h0, 1'b0, 8'h0, 16'h0, 32'hffff_ffff);
        queue_request(OP_CLEAR, 16'h0, 32'h0, 1'b0, 8'h0, 16'h0, 32'h0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 83;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 83;
                end
                default: begin
                    send_idle_pct = 6;
                    recv_stall_pct = 6;
                end
            endcase
            round_now = $urandom;
            phase_target = requests_made + 62;
            while (requests_made < phase_target) begin
                queue_random_scene();
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("** ordered_timer_event_table: PASSED **");
        end else begin
            $display("** ordered_timer_event_table: FAILED **");
        end
        $finish;
    end

endmodule
